/* src/lifegen_pkg.sv */
package lifegen_pkg;

    // Grid limits
    localparam int MAX_WIDTH  = 32;
    localparam int MAX_HEIGHT = 4096;

    // Derived widths
    localparam int COL_W  = $clog2(MAX_WIDTH);        // column index
    localparam int ROW_W  = $clog2(MAX_HEIGHT);       // row index
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);    // effective width
    localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);   // effective height
    localparam int STEP_W = $clog2(MAX_WIDTH + 3);    // results per job, up to width+2

    // Configuration port
    localparam int GRID_WIDTH_REG_W  = 6;
    localparam int GRID_HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W        = 13;
    localparam int CFG_INDEX_W       = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    localparam logic [GRID_WIDTH_REG_W-1:0]  GRID_WIDTH_RESET  = 6'd32;
    localparam logic [GRID_HEIGHT_REG_W-1:0] GRID_HEIGHT_RESET = 13'd32;

    // Job queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified input: up to two ready-made cells, then an optional
    // end-of-frame flush of the last row against an all-dead row below.
    typedef struct packed {
        logic [1:0]           pre_count;
        logic                 pre_first;
        logic                 pre_second;
        logic                 flush;
        logic [MAX_WIDTH-1:0] flush_above;
        logic [MAX_WIDTH-1:0] flush_here;
        logic [WCNT_W-1:0]    width;
    } lifegen_job_t;

    // B3/S23 rule for the cell at col of the middle row; edges are dead
    function automatic logic lifegen_cell(
        input logic [MAX_WIDTH-1:0] above,
        input logic [MAX_WIDTH-1:0] here,
        input logic [MAX_WIDTH-1:0] below,
        input logic [COL_W-1:0]     col
    );
        logic [MAX_WIDTH+1:0] pad_a;
        logic [MAX_WIDTH+1:0] pad_h;
        logic [MAX_WIDTH+1:0] pad_b;
        logic [2:0]           win_a;
        logic [2:0]           win_h;
        logic [2:0]           win_b;
        logic [3:0]           n;
        pad_a = {1'b0, above, 1'b0};
        pad_h = {1'b0, here, 1'b0};
        pad_b = {1'b0, below, 1'b0};
        win_a = pad_a[col +: 3];
        win_h = pad_h[col +: 3];
        win_b = pad_b[col +: 3];
        n = 4'(win_a[0]) + 4'(win_a[1]) + 4'(win_a[2])
          + 4'(win_h[0]) + 4'(win_h[2])
          + 4'(win_b[0]) + 4'(win_b[1]) + 4'(win_b[2]);
        if (win_h[1])
            return (n == 4'd2) || (n == 4'd3);
        return n == 4'd3;
    endfunction

endpackage

/* src/lifegen_front.sv */
module lifegen_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [lifegen_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lifegen_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   cell_alive,
    input  logic                                   q_full,
    output logic                                   push,
    output lifegen_pkg::lifegen_job_t              push_job
);
    import lifegen_pkg::*;

    logic [GRID_WIDTH_REG_W-1:0]  grid_width_reg, grid_width_next;
    logic [GRID_HEIGHT_REG_W-1:0] grid_height_reg, grid_height_next;
    logic [MAX_WIDTH-1:0]         older_reg, older_next;
    logic [MAX_WIDTH-1:0]         prev_reg, prev_next;
    logic [MAX_WIDTH-1:0]         inc_reg, inc_next;
    logic [COL_W-1:0]             col_reg, col_next;
    logic [ROW_W-1:0]             row_reg, row_next;

    logic [WCNT_W-1:0]    eff_w;
    logic [HCNT_W-1:0]    eff_h;
    logic [COL_W-1:0]     last_col;
    logic [ROW_W-1:0]     last_row;
    logic [MAX_WIDTH-1:0] inc_now;
    logic                 accept;
    logic                 col_is_last;
    logic                 row_is_last;
    logic                 col_nonzero;
    logic                 row_nonzero;
    logic                 val_left;
    logic                 val_here;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Effective grid size: zero reads as one, oversize saturates
    always_comb
    begin
        if (grid_width_reg == '0)
            eff_w = WCNT_W'(1);
        else if (grid_width_reg > GRID_WIDTH_REG_W'(MAX_WIDTH))
            eff_w = WCNT_W'(MAX_WIDTH);
        else
            eff_w = WCNT_W'(grid_width_reg);

        if (grid_height_reg == '0)
            eff_h = HCNT_W'(1);
        else if (grid_height_reg > GRID_HEIGHT_REG_W'(MAX_HEIGHT))
            eff_h = HCNT_W'(MAX_HEIGHT);
        else
            eff_h = HCNT_W'(grid_height_reg);
    end

    assign last_col = COL_W'(eff_w - WCNT_W'(1));
    assign last_row = ROW_W'(eff_h - HCNT_W'(1));

    // Incoming row with the current cell merged in
    assign inc_now = inc_reg | (MAX_WIDTH'(cell_alive) << col_reg);

    assign col_is_last = (col_reg == last_col);
    assign row_is_last = (row_reg == last_row);
    assign col_nonzero = (col_reg != '0);
    assign row_nonzero = (row_reg != '0);

    // Cells of the row above that are now complete
    assign val_left = lifegen_cell(older_reg, prev_reg, inc_now, col_reg - COL_W'(1));
    assign val_here = lifegen_cell(older_reg, prev_reg, inc_now, col_reg);

    // Classify the beat into a job for the back end
    always_comb
    begin
        push_job.pre_count   = row_nonzero ? ({1'b0, col_nonzero} + {1'b0, col_is_last})
                                           : 2'd0;
        push_job.pre_first   = col_nonzero ? val_left : val_here;
        push_job.pre_second  = val_here;
        push_job.flush       = col_is_last && row_is_last;
        push_job.flush_above = prev_reg;
        push_job.flush_here  = inc_now;
        push_job.width       = eff_w;
    end

    assign push = accept && ((push_job.pre_count != 2'd0) || push_job.flush);

    // Config writes restart the frame; accepted beats walk the raster
    always_comb
    begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        older_next       = older_reg;
        prev_next        = prev_reg;
        inc_next         = inc_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  grid_width_next  = GRID_WIDTH_REG_W'(cfg_data);
                REG_GRID_HEIGHT: grid_height_next = cfg_data;
                default: ;
            endcase
            older_next = '0;
            prev_next  = '0;
            inc_next   = '0;
            col_next   = '0;
            row_next   = '0;
        end
        else if (accept)
        begin
            if (col_is_last && row_is_last)
            begin
                older_next = '0;
                prev_next  = '0;
                inc_next   = '0;
                col_next   = '0;
                row_next   = '0;
            end
            else if (col_is_last)
            begin
                older_next = prev_reg;
                prev_next  = inc_now;
                inc_next   = '0;
                col_next   = '0;
                row_next   = row_reg + ROW_W'(1);
            end
            else
            begin
                inc_next = inc_now;
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RESET;
            grid_height_reg <= GRID_HEIGHT_RESET;
            older_reg       <= '0;
            prev_reg        <= '0;
            inc_reg         <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
        end
        else
        begin
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
            older_reg       <= older_next;
            prev_reg        <= prev_next;
            inc_reg         <= inc_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
        end
    end

endmodule

/* src/lifegen_queue.sv */
module lifegen_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  lifegen_pkg::lifegen_job_t push_job,
    output logic                      full,
    input  logic                      pop,
    output logic                      head_valid,
    output lifegen_pkg::lifegen_job_t head_job
);
    import lifegen_pkg::*;

    lifegen_job_t      slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

/* src/lifegen_back.sv */
module lifegen_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      head_valid,
    input  lifegen_pkg::lifegen_job_t head_job,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      next_alive,
    output logic                      run_last,
    output logic                      frame_last
);
    import lifegen_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              next_alive_reg, next_alive_next;
    logic              run_last_reg, run_last_next;
    logic              frame_last_reg, frame_last_next;

    logic [STEP_W-1:0] pre_steps;
    logic [STEP_W-1:0] total_steps;
    logic [STEP_W-1:0] flush_step;
    logic              load;
    logic              is_last;
    logic              in_pre;
    logic              cell_value;

    // Output register takes a beat when empty or being drained
    assign load = head_valid && (!out_valid_reg || out_ready);

    assign pre_steps   = STEP_W'(head_job.pre_count);
    assign total_steps = pre_steps + (head_job.flush ? STEP_W'(head_job.width) : '0);
    assign is_last     = (step_reg == total_steps - STEP_W'(1));
    assign in_pre      = (step_reg < pre_steps);
    assign flush_step  = step_reg - pre_steps;
    assign pop         = load && is_last;

    // Value for the current step: a ready-made cell or one flush column
    always_comb
    begin
        if (in_pre)
            cell_value = (step_reg == '0) ? head_job.pre_first : head_job.pre_second;
        else
            cell_value = lifegen_cell(head_job.flush_above, head_job.flush_here, '0,
                                      flush_step[COL_W-1:0]);
    end

    // Step counter and output register next values
    always_comb
    begin
        step_next       = step_reg;
        out_valid_next  = out_valid_reg;
        next_alive_next = next_alive_reg;
        run_last_next   = run_last_reg;
        frame_last_next = frame_last_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (load)
        begin
            step_next       = is_last ? '0 : step_reg + STEP_W'(1);
            out_valid_next  = 1'b1;
            next_alive_next = cell_value;
            run_last_next   = is_last;
            frame_last_next = is_last && head_job.flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        next_alive_reg <= next_alive_next;
        run_last_reg   <= run_last_next;
        frame_last_reg <= frame_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign next_alive = next_alive_reg;
    assign run_last   = run_last_reg;
    assign frame_last = frame_last_reg;

endmodule

/* src/life_automaton_generation_unit.sv */
// Streaming Game of Life (B3/S23) generation step. Cells of one generation
// enter in raster order, one per beat, and the next generation leaves in the
// same order, one cell per beat, with edges treated as dead. The input side
// takes a cell every clock while its four-entry job queue has room; a cell in
// the last column of a later row yields up to two output cells, and the last
// cell of the frame up to width+2, so the output channel, at one cell per
// clock while out_ready is high, sets the pace. Over a whole frame
// width*height cells go in and out, and in_ready drops only while the queue
// is full, as around row ends, the end-of-frame flush or output stalls.
// Output lags input by about one row; a taller grid's first row gives nothing
// until the second arrives. Writing grid_width (index 0) or grid_height
// (index 1) restarts the frame; write only while no cells are in flight.
module life_automaton_generation_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lifegen_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lifegen_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cell_alive,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                next_alive,
    output logic                                run_last,
    output logic                                frame_last
);
    import lifegen_pkg::*;

    logic         q_full;
    logic         q_push;
    logic         q_pop;
    logic         head_valid;
    lifegen_job_t push_job;
    lifegen_job_t head_job;

    // Front: raster tracking, row buffers, classification
    lifegen_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cell_alive (cell_alive),
        .q_full     (q_full),
        .push       (q_push),
        .push_job   (push_job)
    );

    // Job queue between the two halves
    lifegen_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Back: expands jobs into output beats
    lifegen_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .next_alive (next_alive),
        .run_last   (run_last),
        .frame_last (frame_last)
    );

    // The final cell of a generation always closes its job
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |-> run_last)
        else $error("frame_last without run_last");

    // An output beat only appears after a queued job was available
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(head_valid))
        else $error("output beat without a queued job");

    // A job is only released together with a beat into the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid)
        else $error("job released without an output beat");

endmodule

/* tb/sv/life_automaton_generation_unit_test.sv */
`timescale 1ns / 100ps

module life_automaton_generation_unit_test;
    import lifegen_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int MAX_GAP       = 17;
    localparam int SETTLE_CYCLES = 24;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_CELLS  = 300;

    // one output beat
    typedef struct packed {
        logic alive;
        logic run_end;
        logic frame_end;
    } cell_result_t;

    // a lone cell on a 1x1 grid always dies and closes the frame
    localparam cell_result_t LONE_CELL = '{1'b0, 1'b1, 1'b1};

    typedef enum logic {PLAN_WRITE, PLAN_CELL} plan_kind_t;

    typedef struct packed {
        plan_kind_t             kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        logic                   alive;
        logic                   typed;
        cell_result_t           want;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   cell_alive;
    logic                   out_valid;
    logic                   out_ready;
    logic                   next_alive;
    logic                   run_last;
    logic                   frame_last;

    // generation predictor state
    logic [GRID_WIDTH_REG_W-1:0]  grid_cols_reg;
    logic [GRID_HEIGHT_REG_W-1:0] grid_rows_reg;
    logic [MAX_WIDTH-1:0]         row_above;
    logic [MAX_WIDTH-1:0]         row_middle;
    logic [MAX_WIDTH-1:0]         row_filling;
    int                           feed_col;
    int                           feed_row;
    int                           emit_col;
    int                           emit_row;
    cell_result_t                 step_cells[$];
    cell_result_t                 pending_cells[$];

    // stimulus control and bookkeeping
    logic         send_burst;
    logic         recv_burst;
    logic         accept_typed;
    cell_result_t accept_want;
    plan_row_t    plan[$];
    int           fail_count;
    int           cells_in;
    int           cells_out;
    int           reg_writes;
    int           quiet_cycles;

    life_automaton_generation_unit dut (.*);

    // clock
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // zero counts as one, oversize saturates
    function automatic int clamp_dim(input int value, input int top);
        if (value == 0)
            return 1;
        return (value > top) ? top : value;
    endfunction

    function automatic void restart_frame();
        row_above   = '0;
        row_middle  = '0;
        row_filling = '0;
        feed_col    = 0;
        feed_row    = 0;
        emit_col    = 0;
        emit_row    = 0;
    endfunction

    // cells beyond the grid edge are dead
    function automatic int cell_at(input logic [MAX_WIDTH-1:0] row, input int i, input int w);
        if (i < 0 || i >= w)
            return 0;
        return int'(row[i]);
    endfunction

    function automatic logic b3s23_rule(input logic [MAX_WIDTH-1:0] above,
                                        input logic [MAX_WIDTH-1:0] here,
                                        input logic [MAX_WIDTH-1:0] below,
                                        input int col, input int w);
        int n;
        n = 0;
        for (int d = -1; d <= 1; d++)
        begin
            n += cell_at(above, col + d, w) + cell_at(below, col + d, w);
            if (d != 0)
                n += cell_at(here, col + d, w);
        end
        if (cell_at(here, col, w) == 1)
            return (n == 2) || (n == 3);
        return n == 3;
    endfunction

    function automatic void emit_cell(input logic alive, input int w, input int h);
        step_cells.push_back('{alive, 1'b0, (emit_row == h - 1) && (emit_col == w - 1)});
        emit_col++;
        if (emit_col >= w)
        begin
            emit_col = 0;
            emit_row++;
            if (emit_row >= h)
                emit_row = 0;
        end
    endfunction

    // one input cell in, the output cells it releases into step_cells
    function automatic void advance_with_cell(input logic alive);
        int           w;
        int           h;
        int           c;
        int           r;
        cell_result_t last;
        step_cells.delete();
        w = clamp_dim(int'(grid_cols_reg), MAX_WIDTH);
        h = clamp_dim(int'(grid_rows_reg), MAX_HEIGHT);
        if (feed_col >= w || feed_row >= h)
            restart_frame();
        c = feed_col;
        r = feed_row;
        if (alive)
            row_filling[c] = 1'b1;
        // cell to the upper left, plus the row's last cell at a row end
        if (r >= 1)
        begin
            if (c >= 1)
                emit_cell(b3s23_rule(row_above, row_middle, row_filling, c - 1, w), w, h);
            if (c == w - 1)
                emit_cell(b3s23_rule(row_above, row_middle, row_filling, c, w), w, h);
        end
        if (c == w - 1)
        begin
            if (r == h - 1)
            begin
                // end of frame: last row against a dead row below
                for (int x = 0; x < w; x++)
                    emit_cell(b3s23_rule(row_middle, row_filling, '0, x, w), w, h);
                restart_frame();
            end
            else
            begin
                row_above   = row_middle;
                row_middle  = row_filling;
                row_filling = '0;
                feed_col    = 0;
                feed_row    = r + 1;
            end
        end
        else
            feed_col = c + 1;
        if (step_cells.size() != 0)
        begin
            last         = step_cells.pop_back();
            last.run_end = 1'b1;
            step_cells.push_back(last);
        end
    endfunction

    function automatic void check_field(input string name, input logic want, input logic got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0b, got %0b", name, want, got);
            fail_count++;
        end
    endfunction

    // monitor: register writes, accepted cells, accepted results
    always @(posedge clk)
    begin : watch_channels
        cell_result_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_GRID_WIDTH)
                    grid_cols_reg = cfg_data[GRID_WIDTH_REG_W-1:0];
                else if (cfg_index == REG_GRID_HEIGHT)
                    grid_rows_reg = cfg_data[GRID_HEIGHT_REG_W-1:0];
                restart_frame();
                reg_writes++;
            end
            if (in_valid && in_ready)
            begin
                advance_with_cell(cell_alive);
                if (accept_typed)
                begin
                    pending_cells.push_back(accept_want);
                    step_cells.delete();
                end
                else
                    while (step_cells.size() != 0)
                        pending_cells.push_back(step_cells.pop_front());
                cells_in++;
            end
            if (out_valid && out_ready)
            begin
                cells_out++;
                if (pending_cells.size() == 0)
                begin
                    $error("unexpected beat: next_alive=%0b run_last=%0b frame_last=%0b",
                           next_alive, run_last, frame_last);
                    fail_count++;
                end
                else
                begin
                    want = pending_cells.pop_front();
                    check_field("next_alive", want.alive, next_alive);
                    check_field("run_last", want.run_end, run_last);
                    check_field("frame_last", want.frame_end, frame_last);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // watchdog
    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge clk);
        $display("no beat on either channel for %0d cycles", QUIET_LIMIT);
        $display("life_automaton_generation_unit_test failed");
        $finish;
    end

    // result side: random stalls per beat, none in burst mode
    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge clk);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // send one cell; returns at the accepting edge with valid still high
    task automatic drive_cell(input logic alive, input logic typed, input cell_result_t want);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        cell_alive   <= alive;
        accept_typed <= typed;
        accept_want  <= want;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(negedge clk);
    endtask

    // idle: nothing owed, and cells that release nothing are done too
    task automatic quiesce();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic setup_grid(input logic [CFG_DATA_W-1:0] cols, input logic [CFG_DATA_W-1:0] rows);
        quiesce();
        write_reg(REG_GRID_WIDTH, cols);
        write_reg(REG_GRID_HEIGHT, rows);
    endtask

    function automatic void add_write(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] value);
        plan.push_back('{PLAN_WRITE, idx, value, 1'b0, 1'b0, '0});
    endfunction

    function automatic void add_cell(input logic alive, input logic typed = 1'b0,
                                     input cell_result_t want = '0);
        plan.push_back('{PLAN_CELL, '0, '0, alive, typed, want});
    endfunction

    initial
    begin : stimulus
        int                  setups;
        int                  rand_cells;
        int                  phase;
        int                  w_eff;
        int                  h_eff;
        int                  frame;
        int                  items;
        int                  pct;
        logic [5:0]          wsel;
        logic [12:0]         hsel;
        logic                last_was_cell;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        cell_alive   = 1'b0;
        accept_typed = 1'b0;
        accept_want  = '0;
        send_burst   = 1'b0;
        recv_burst   = 1'b0;
        fail_count   = 0;
        cells_in     = 0;
        cells_out    = 0;
        reg_writes   = 0;
        quiet_cycles = 0;
        setups       = 0;
        grid_cols_reg = GRID_WIDTH_RESET;
        grid_rows_reg = GRID_HEIGHT_RESET;
        restart_frame();

        // reset size 32x32: a partial first row releases nothing
        add_cell(1'b1);
        add_cell(1'b0);
        add_cell(1'b1);
        add_cell(1'b1);
        // 1x1 grid: each cell dies alone and ends the frame
        add_write(REG_GRID_WIDTH, 13'd1);
        add_write(REG_GRID_HEIGHT, 13'd1);
        add_cell(1'b1, 1'b1, LONE_CELL);
        add_cell(1'b0, 1'b1, LONE_CELL);
        // zero sizes are taken as one
        add_write(REG_GRID_WIDTH, 13'd0);
        add_write(REG_GRID_HEIGHT, 13'd0);
        add_cell(1'b1, 1'b1, LONE_CELL);
        // one-row grid flushes the whole row on its last cell
        add_write(REG_GRID_WIDTH, 13'd2);
        add_cell(1'b1);
        add_cell(1'b1);
        // 3x3 blinker, cut short by a rewrite that restarts the frame
        add_write(REG_GRID_WIDTH, 13'd3);
        add_write(REG_GRID_HEIGHT, 13'd3);
        add_cell(1'b0);
        add_cell(1'b1);
        add_cell(1'b0);
        add_cell(1'b0);
        add_cell(1'b1);
        add_write(REG_GRID_HEIGHT, 13'd3);
        repeat (3)
        begin
            add_cell(1'b0);
            add_cell(1'b1);
            add_cell(1'b0);
        end

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // directed table
        last_was_cell = 1'b0;
        foreach (plan[i])
        begin
            if (plan[i].kind == PLAN_WRITE)
            begin
                if (last_was_cell)
                    quiesce();
                write_reg(plan[i].reg_index, plan[i].reg_value);
                last_was_cell = 1'b0;
            end
            else
            begin
                drive_cell(plan[i].alive, plan[i].typed, plan[i].want);
                last_was_cell = 1'b1;
            end
        end

        // random grids: mostly whole frames, some cut short
        rand_cells = 0;
        phase      = 0;
        while (rand_cells < RANDOM_CELLS)
        begin
            case (phase)
                0: begin wsel = 6'd32; hsel = 13'd2; end
                1: begin wsel = 6'd63; hsel = 13'd3; end
                2: begin wsel = 6'($urandom_range(2, 6)); hsel = 13'd4096; end
                default:
                begin
                    case ($urandom_range(0, 9))
                        0:       wsel = 6'd0;
                        1:       wsel = 6'd1;
                        2:       wsel = 6'd32;
                        3:       wsel = 6'($urandom_range(33, 63));
                        default: wsel = 6'($urandom_range(2, 8));
                    endcase
                    case ($urandom_range(0, 7))
                        0:       hsel = 13'd0;
                        1:       hsel = 13'd1;
                        2:       hsel = 13'($urandom_range(4097, 8191));
                        default: hsel = 13'($urandom_range(2, 6));
                    endcase
                end
            endcase
            // width write carries random junk above its six bits
            setup_grid({7'($urandom), wsel}, hsel);
            setups++;
            w_eff = clamp_dim(int'(wsel), MAX_WIDTH);
            h_eff = clamp_dim(int'(hsel), MAX_HEIGHT);
            frame = w_eff * h_eff;
            if (h_eff > 64)
                items = $urandom_range(w_eff, 4 * w_eff);
            else if ($urandom_range(0, 4) == 0)
                items = $urandom_range(1, frame);
            else
                items = (frame <= 48) ? frame * $urandom_range(1, 2) : frame;
            // stay within the cell budget
            if (items > RANDOM_CELLS - rand_cells)
                items = RANDOM_CELLS - rand_cells;
            pct        = 25 * $urandom_range(0, 4);
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            repeat (items)
            begin
                // sender holds off until the output side has caught up
                if (rand_cells == RANDOM_CELLS / 2 || $urandom_range(0, 59) == 0)
                    drain_results();
                drive_cell($urandom_range(0, 99) < pct, 1'b0, '0);
                rand_cells++;
            end
            phase++;
        end

        quiesce();
        $display("%0d cells in, %0d cells out, %0d register writes", cells_in, cells_out,
                 reg_writes);
        $display("%0d random grid setups incl. zero, one and saturating sizes", setups);
        if (fail_count == 0)
            $display("life_automaton_generation_unit_test passed");
        else
            $display("life_automaton_generation_unit_test failed");
        $finish;
    end

endmodule

/* sim.f */
src/lifegen_pkg.sv
src/lifegen_front.sv
src/lifegen_queue.sv
src/lifegen_back.sv
src/life_automaton_generation_unit.sv
tb/sv/life_automaton_generation_unit_test.sv
